// File: hdl/sfsg_pkg.sv
// Shared types, constants and the stroke glyph table of the stroke-font segment generator.
// No dependencies; every other file in hdl/ imports this package.
package sfsg_pkg;

  localparam int COORD_BITS_DEFAULT = 16;

  // Field widths of the item and segment channels
  localparam int CMD_W    = 2;
  localparam int POS_W    = 16;
  localparam int CHAR_W   = 8;
  localparam int KIND_W   = 3;
  localparam int LEN_W    = 7;
  localparam int COLOR_W  = 8;

  // Register port
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam logic [COLOR_W-1:0] GLYPH_SIZE_RESET = 8'd16;
  localparam logic [COLOR_W-1:0] COLOR_RESET      = 8'hFF;

  typedef enum logic [2:0] {
    REG_GLYPH_SIZE   = 3'd0,
    REG_TOP_RED      = 3'd1,
    REG_TOP_GREEN    = 3'd2,
    REG_TOP_BLUE     = 3'd3,
    REG_BOTTOM_RED   = 3'd4,
    REG_BOTTOM_GREEN = 3'd5,
    REG_BOTTOM_BLUE  = 3'd6
  } reg_index_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_CHAR   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Segment kinds
  localparam logic [KIND_W-1:0] KIND_HORZ    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VERT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DIAG_DL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIAG_DR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WIDTH   = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DASH       = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_QUESTION   = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

  // Glyph table
  localparam int GLYPH_COUNT  = 39;
  localparam int GLYPH_IDX_W  = 6;
  localparam int BOX_COUNT    = 4;
  localparam int BOX_IDX_W    = 2;
  localparam int STROKE_COUNT = 6;
  localparam int STK_IDX_W    = 3;

  localparam logic [GLYPH_IDX_W-1:0] GLYPH_DIGIT_BASE = 6'd26;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_DASH       = 6'd36;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_UNDERSCORE = 6'd37;
  localparam logic [GLYPH_IDX_W-1:0] GLYPH_QUESTION   = 6'd38;

  // Stroke bit positions within a box, in emission order
  localparam logic [STK_IDX_W-1:0] STK_TOP = 3'd0;
  localparam logic [STK_IDX_W-1:0] STK_BOT = 3'd1;
  localparam logic [STK_IDX_W-1:0] STK_LFT = 3'd2;
  localparam logic [STK_IDX_W-1:0] STK_RGT = 3'd3;
  localparam logic [STK_IDX_W-1:0] STK_DDL = 3'd4;
  localparam logic [STK_IDX_W-1:0] STK_DDR = 3'd5;

  typedef logic [STROKE_COUNT-1:0] box_mask_t;
  // [3] top-left, [2] top-right, [1] bottom-right, [0] bottom-left:
  // ascending bit order of the flat vector is the emission order.
  typedef logic [BOX_COUNT-1:0][STROKE_COUNT-1:0] glyph_row_t;

  localparam box_mask_t SK_NONE = 6'h00;
  localparam box_mask_t SK_TOP  = 6'h01;
  localparam box_mask_t SK_BOT  = 6'h02;
  localparam box_mask_t SK_LFT  = 6'h04;
  localparam box_mask_t SK_RGT  = 6'h08;
  localparam box_mask_t SK_DDL  = 6'h10;
  localparam box_mask_t SK_DDR  = 6'h20;

  // Rows: A-Z, 0-9, '-', '_', '?'; columns top-left, top-right, bottom-right, bottom-left
  localparam glyph_row_t GLYPH_ROM [GLYPH_COUNT] = '{
    '{SK_TOP|SK_BOT|SK_LFT, SK_TOP|SK_BOT|SK_RGT, SK_RGT, SK_LFT},
    '{SK_TOP|SK_LFT|SK_BOT, SK_TOP|SK_DDL, SK_BOT|SK_DDR, SK_BOT|SK_LFT},
    '{SK_LFT|SK_TOP, SK_TOP, SK_BOT, SK_LFT|SK_BOT},
    '{SK_TOP|SK_LFT, SK_TOP|SK_RGT, SK_DDL, SK_BOT|SK_LFT},
    '{SK_TOP|SK_LFT, SK_TOP|SK_DDL, SK_BOT, SK_BOT|SK_LFT},
    '{SK_TOP|SK_LFT|SK_BOT, SK_TOP, SK_NONE, SK_LFT},
    '{SK_DDL, SK_TOP, SK_TOP|SK_BOT|SK_RGT, SK_BOT|SK_LFT},
    '{SK_LFT|SK_BOT, SK_RGT|SK_BOT, SK_RGT, SK_LFT},
    '{SK_RGT, SK_NONE, SK_NONE, SK_RGT},
    '{SK_NONE, SK_RGT, SK_BOT|SK_RGT, SK_BOT|SK_LFT},
    '{SK_LFT|SK_BOT, SK_DDL, SK_DDR, SK_LFT},
    '{SK_LFT, SK_NONE, SK_BOT, SK_BOT|SK_LFT},
    '{SK_LFT|SK_DDR, SK_DDL|SK_RGT, SK_RGT, SK_LFT},
    '{SK_LFT|SK_DDR, SK_RGT, SK_RGT|SK_DDR, SK_LFT},
    '{SK_LFT|SK_TOP, SK_TOP|SK_RGT, SK_RGT|SK_BOT, SK_LFT|SK_BOT},
    '{SK_LFT|SK_TOP|SK_BOT, SK_TOP|SK_BOT|SK_RGT, SK_NONE, SK_LFT},
    '{SK_LFT|SK_TOP, SK_TOP|SK_RGT, SK_DDR|SK_RGT|SK_BOT, SK_LFT|SK_BOT},
    '{SK_LFT|SK_TOP|SK_BOT, SK_TOP|SK_BOT|SK_RGT, SK_DDR, SK_LFT},
    '{SK_LFT|SK_TOP|SK_BOT, SK_TOP|SK_BOT, SK_RGT|SK_BOT, SK_BOT},
    '{SK_TOP|SK_RGT, SK_TOP, SK_LFT, SK_NONE},
    '{SK_LFT, SK_RGT, SK_RGT|SK_BOT, SK_BOT|SK_LFT},
    '{SK_LFT, SK_RGT, SK_DDL, SK_BOT|SK_LFT},
    '{SK_LFT, SK_RGT, SK_RGT|SK_DDR, SK_LFT|SK_DDL},
    '{SK_DDR, SK_DDL, SK_DDR, SK_DDL},
    '{SK_DDR, SK_DDL, SK_NONE, SK_RGT},
    '{SK_TOP, SK_TOP|SK_DDL, SK_BOT, SK_BOT|SK_DDL},
    '{SK_LFT|SK_TOP, SK_TOP|SK_RGT, SK_RGT|SK_BOT, SK_LFT|SK_BOT},
    '{SK_RGT, SK_NONE, SK_NONE, SK_RGT},
    '{SK_TOP|SK_BOT, SK_TOP|SK_BOT|SK_RGT, SK_BOT, SK_BOT|SK_LFT},
    '{SK_TOP|SK_BOT, SK_TOP|SK_BOT|SK_RGT, SK_BOT|SK_RGT, SK_BOT},
    '{SK_LFT|SK_BOT, SK_BOT|SK_RGT, SK_RGT, SK_NONE},
    '{SK_LFT|SK_TOP|SK_BOT, SK_TOP|SK_BOT, SK_RGT|SK_BOT, SK_BOT},
    '{SK_TOP|SK_BOT|SK_LFT, SK_TOP|SK_BOT, SK_RGT|SK_BOT, SK_LFT|SK_BOT},
    '{SK_TOP, SK_TOP|SK_RGT, SK_RGT, SK_NONE},
    '{SK_TOP|SK_BOT|SK_LFT, SK_TOP|SK_BOT|SK_RGT, SK_RGT|SK_BOT, SK_LFT|SK_BOT},
    '{SK_TOP|SK_BOT|SK_LFT, SK_TOP|SK_BOT|SK_RGT, SK_RGT|SK_BOT, SK_BOT},
    '{SK_BOT, SK_BOT, SK_NONE, SK_NONE},
    '{SK_NONE, SK_NONE, SK_BOT, SK_BOT},
    '{SK_DDL, SK_DDR|SK_BOT, SK_LFT, SK_NONE}
  };

  typedef struct packed {
    logic                   found;
    logic [GLYPH_IDX_W-1:0] index;
  } glyph_hit_t;

  // Case-folded glyph lookup
  function automatic glyph_hit_t glyph_lookup(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] c;
    glyph_hit_t        hit;
    c   = code;
    hit = '{found: 1'b0, index: '0};
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_OFFSET;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      hit.found = 1'b1;
      hit.index = GLYPH_IDX_W'(c - CH_UPPER_A);
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      hit.found = 1'b1;
      hit.index = GLYPH_IDX_W'(c - CH_DIGIT_0) + GLYPH_DIGIT_BASE;
    end else if (c == CH_DASH) begin
      hit.found = 1'b1;
      hit.index = GLYPH_DASH;
    end else if (c == CH_UNDERSCORE) begin
      hit.found = 1'b1;
      hit.index = GLYPH_UNDERSCORE;
    end else if (c == CH_QUESTION) begin
      hit.found = 1'b1;
      hit.index = GLYPH_QUESTION;
    end
    return hit;
  endfunction

  // Item class, settled at transfer time
  typedef enum logic [2:0] {
    IK_START   = 3'd0,
    IK_GLYPH   = 3'd1,
    IK_SPACE   = 3'd2,
    IK_NEWLINE = 3'd3,
    IK_GAP     = 3'd4,
    IK_FINISH  = 3'd5,
    IK_NOP     = 3'd6
  } item_kind_t;

  // Microprogram
  localparam int STEP_COUNT = 8;

  typedef enum logic [2:0] {
    ST_WAIT     = 3'd0,
    ST_DECODE   = 3'd1,
    ST_START    = 3'd2,
    ST_EMIT     = 3'd3,
    ST_ADV_CELL = 3'd4,
    ST_ADV_GAP  = 3'd5,
    ST_NEWLINE  = 3'd6,
    ST_FINISH   = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    OP_LATCH   = 3'd0,
    OP_START   = 3'd1,
    OP_EMIT    = 3'd2,
    OP_CELL    = 3'd3,
    OP_GAP     = 3'd4,
    OP_NEWLINE = 3'd5,
    OP_REPORT  = 3'd6,
    OP_NONE    = 3'd7
  } dp_op_t;

  typedef enum logic [2:0] {
    JC_ALWAYS    = 3'd0,
    JC_ACCEPT    = 3'd1,
    JC_DISPATCH  = 3'd2,
    JC_LAST_SENT = 3'd3,
    JC_OUT_FREE  = 3'd4
  } jump_t;

  typedef struct packed {
    logic   in_ready;
    dp_op_t op;
    jump_t  jump;
    step_t  target;
  } ucode_word_t;

  typedef struct packed {
    logic       accept;
    logic       out_free;
    logic       last_stroke;
    item_kind_t kind;
  } seq_status_t;

endpackage

// File: hdl/sfsg_ifs.sv
// Valid/ready channel interfaces: character items in, line segments out.
// Depends on sfsg_pkg for field widths.
interface sfsg_item_if
  import sfsg_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [POS_W-1:0] start_x;
  logic signed [POS_W-1:0] start_y;
  logic [CHAR_W-1:0]       char_code;

  modport source (output valid, cmd, start_x, start_y, char_code, input ready);
  modport sink   (input valid, cmd, start_x, start_y, char_code, output ready);
endinterface

interface sfsg_seg_if
  import sfsg_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       seg_kind;
  logic signed [POS_W-1:0] seg_x;
  logic signed [POS_W-1:0] seg_y;
  logic [LEN_W-1:0]        seg_len;
  logic [COLOR_W-1:0]      red;
  logic [COLOR_W-1:0]      green;
  logic [COLOR_W-1:0]      blue;
  logic                    last;

  modport source (output valid, seg_kind, seg_x, seg_y, seg_len, red, green, blue, last,
                  input ready);
  modport sink   (input valid, seg_kind, seg_x, seg_y, seg_len, red, green, blue, last,
                  output ready);
endinterface

// File: hdl/stroke_font_segment_generator.sv
// Stroke-font segment generator top level: register port, cursor datapath, output register.
// Depends on sfsg_pkg, sfsg_ifs (sfsg_item_if, sfsg_seg_if) and sfsg_seq.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------------------
//  item     in   valid/ready        cmd, start_x, start_y, char_code
//  seg      out  valid/ready        seg_kind, seg_x, seg_y, seg_len, rgb, last
//  apb      in   psel/penable/pwr   paddr (reg i at 4*i), pwdata, prdata; pready=1
//
// Each item passes the wait and decode steps, then its action steps: start, cell or gap
// advance, newline or finish, none for command three; a glyph with n strokes (2..10) sends
// one stroke per cycle in the emit step, then advances the cell; stalls hold emit and finish.
// The finished segment sits in the output register while the sequencer returns
// to its wait step, so the next item transfer can overlap a stalled result.
// Reset (rst, synchronous) loads glyph_size 16, all colors 255, zeroes the cursor.
module stroke_font_segment_generator
  import sfsg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  sfsg_item_if.sink          item,
  sfsg_seg_if.source         seg
);

  // ---------------- configuration registers ----------------
  logic [COLOR_W-1:0] glyph_size;
  logic [COLOR_W-1:0] top_red, top_green, top_blue;
  logic [COLOR_W-1:0] bottom_red, bottom_green, bottom_blue;
  reg_index_t         cfg_sel;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_sel   = reg_index_t'(paddr[PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_size   <= GLYPH_SIZE_RESET;
      top_red      <= COLOR_RESET;
      top_green    <= COLOR_RESET;
      top_blue     <= COLOR_RESET;
      bottom_red   <= COLOR_RESET;
      bottom_green <= COLOR_RESET;
      bottom_blue  <= COLOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_GLYPH_SIZE:   glyph_size   <= pwdata[COLOR_W-1:0];
        REG_TOP_RED:      top_red      <= pwdata[COLOR_W-1:0];
        REG_TOP_GREEN:    top_green    <= pwdata[COLOR_W-1:0];
        REG_TOP_BLUE:     top_blue     <= pwdata[COLOR_W-1:0];
        REG_BOTTOM_RED:   bottom_red   <= pwdata[COLOR_W-1:0];
        REG_BOTTOM_GREEN: bottom_green <= pwdata[COLOR_W-1:0];
        REG_BOTTOM_BLUE:  bottom_blue  <= pwdata[COLOR_W-1:0];
        default: ;  // address past the register list: dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GLYPH_SIZE:   prdata = PDATA_W'(glyph_size);
      REG_TOP_RED:      prdata = PDATA_W'(top_red);
      REG_TOP_GREEN:    prdata = PDATA_W'(top_green);
      REG_TOP_BLUE:     prdata = PDATA_W'(top_blue);
      REG_BOTTOM_RED:   prdata = PDATA_W'(bottom_red);
      REG_BOTTOM_GREEN: prdata = PDATA_W'(bottom_green);
      REG_BOTTOM_BLUE:  prdata = PDATA_W'(bottom_blue);
      default:          prdata = '0;
    endcase
  end

  // Derived lengths: h = S/2 stroke length, g = S/4 gap
  logic [LEN_W-1:0]   half;
  logic [LEN_W-2:0]   gap;
  logic [COLOR_W:0]   cell_step;  // S + g
  logic [COLOR_W:0]   line_step;  // S + h

  assign half      = glyph_size[COLOR_W-1:1];
  assign gap       = glyph_size[COLOR_W-1:2];
  assign cell_step = (COLOR_W + 1)'(glyph_size) + (COLOR_W + 1)'(gap);
  assign line_step = (COLOR_W + 1)'(glyph_size) + (COLOR_W + 1)'(half);

  // ---------------- sequencer ----------------
  ucode_word_t cw;
  seq_status_t status;
  logic        accept;
  logic        out_free;
  logic        out_load;

  sfsg_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw)
  );

  assign item.ready = cw.in_ready;
  assign accept     = item.valid && item.ready;
  assign out_free   = !seg.valid || seg.ready;
  assign out_load   = out_free && (cw.op == OP_EMIT || cw.op == OP_REPORT);

  // ---------------- item classification ----------------
  glyph_hit_t hit;
  item_kind_t in_kind;

  always_comb begin
    hit = glyph_lookup(item.char_code);
    unique case (cmd_t'(item.cmd))
      CMD_START:  in_kind = IK_START;
      CMD_CHAR: begin
        if (item.char_code == CH_SPACE)        in_kind = IK_SPACE;
        else if (item.char_code == CH_NEWLINE) in_kind = IK_NEWLINE;
        else if (hit.found)                    in_kind = IK_GLYPH;
        else                                   in_kind = IK_GAP;
      end
      CMD_FINISH: in_kind = IK_FINISH;
      default:    in_kind = IK_NOP;
    endcase
  end

  // ---------------- cursor datapath ----------------
  logic [COORD_BITS-1:0]   cursor_x;
  logic [COORD_BITS-1:0]   cursor_y;
  logic [COORD_BITS-1:0]   origin_x;
  item_kind_t              job;       // class of the item in progress
  glyph_row_t              strokes;   // strokes still to send, lowest bit first
  logic signed [POS_W-1:0] start_x;
  logic signed [POS_W-1:0] start_y;

  assign status = '{accept: accept, out_free: out_free,
                    last_stroke: (strokes_left == '0), kind: job};

  // Stroke pick: first non-empty box, then lowest stroke bit in it
  glyph_row_t            strokes_left;
  logic                  box_hit;
  logic [BOX_IDX_W-1:0]  box_sel;
  box_mask_t             box_bits;
  logic [STK_IDX_W-1:0]  stroke_sel;
  logic                  upper;
  logic                  right;
  logic                  x_more;
  logic                  y_more;
  logic [1:0]            x_steps;
  logic [1:0]            y_steps;
  logic [KIND_W-1:0]     emit_kind;
  logic [COORD_BITS-1:0] emit_x;
  logic [COORD_BITS-1:0] emit_y;
  logic [COORD_BITS-1:0] report_x;

  // 0, h or 2h
  function automatic logic [LEN_W:0] step_offset(input logic [1:0] n,
                                                 input logic [LEN_W-1:0] h);
    logic [LEN_W:0] off;
    case (n)
      2'd1:    off = {1'b0, h};
      2'd2:    off = {h, 1'b0};
      default: off = '0;
    endcase
    return off;
  endfunction

  always_comb begin
    strokes_left = strokes & (strokes - 1'b1);

    box_hit = 1'b0;
    box_sel = '0;
    for (int b = 0; b < BOX_COUNT; b++) begin
      if (!box_hit && strokes[b] != '0) begin
        box_hit = 1'b1;
        box_sel = BOX_IDX_W'(b);
      end
    end
    box_bits = strokes[box_sel];

    stroke_sel = '0;
    for (int k = STROKE_COUNT - 1; k >= 0; k--) begin
      if (box_bits[k]) stroke_sel = STK_IDX_W'(k);
    end

    // box [3] top-left, [2] top-right, [1] bottom-right, [0] bottom-left
    upper = box_sel[1];
    right = box_sel[1] ^ box_sel[0];

    x_more = 1'b0;
    y_more = 1'b0;
    case (stroke_sel)
      STK_TOP: emit_kind = KIND_HORZ;
      STK_BOT: begin
        emit_kind = KIND_HORZ;
        y_more    = 1'b1;
      end
      STK_LFT: emit_kind = KIND_VERT;
      STK_RGT: begin
        emit_kind = KIND_VERT;
        x_more    = 1'b1;
      end
      STK_DDL: begin
        emit_kind = KIND_DIAG_DL;
        x_more    = 1'b1;
      end
      STK_DDR: emit_kind = KIND_DIAG_DR;
      default: emit_kind = KIND_HORZ;
    endcase

    x_steps  = {1'b0, right} + {1'b0, x_more};
    y_steps  = {1'b0, !upper} + {1'b0, y_more};
    emit_x   = cursor_x + COORD_BITS'(step_offset(x_steps, half));
    emit_y   = cursor_y + COORD_BITS'(step_offset(y_steps, half));
    report_x = cursor_x - origin_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      origin_x <= '0;
      job      <= IK_NOP;
      strokes  <= '0;
    end else begin
      unique case (cw.op)
        OP_LATCH: begin
          if (accept) begin
            job     <= in_kind;
            strokes <= GLYPH_ROM[hit.index];
          end
        end
        OP_START: begin
          // sign-extend or wrap the 16-bit start point to the coordinate width
          cursor_x <= COORD_BITS'(start_x);
          origin_x <= COORD_BITS'(start_x);
          cursor_y <= COORD_BITS'(start_y);
        end
        OP_EMIT: begin
          if (out_free) strokes <= strokes_left;
        end
        OP_CELL:    cursor_x <= cursor_x + COORD_BITS'(cell_step);
        OP_GAP:     cursor_x <= cursor_x + COORD_BITS'(gap);
        OP_NEWLINE: begin
          cursor_x <= origin_x;
          cursor_y <= cursor_y + COORD_BITS'(line_step);
        end
        default: ;  // report and decode leave the cursor alone
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_x <= item.start_x;
      start_y <= item.start_y;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
    end else if (out_load) begin
      seg.valid <= 1'b1;
    end else if (seg.ready) begin
      seg.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cw.op == OP_REPORT) begin
        seg.seg_kind <= KIND_WIDTH;
        seg.seg_x    <= POS_W'(report_x);
        seg.seg_y    <= '0;
        seg.seg_len  <= '0;
        seg.red      <= '0;
        seg.green    <= '0;
        seg.blue     <= '0;
        seg.last     <= 1'b1;
      end else begin
        seg.seg_kind <= emit_kind;
        seg.seg_x    <= POS_W'(emit_x);
        seg.seg_y    <= POS_W'(emit_y);
        seg.seg_len  <= half;
        seg.red      <= upper ? top_red   : bottom_red;
        seg.green    <= upper ? top_green : bottom_green;
        seg.blue     <= upper ? top_blue  : bottom_blue;
        seg.last     <= (strokes_left == '0);
      end
    end
  end

  a_emit_has_stroke: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT) |-> (strokes != '0))
    else $error("emit step with no stroke left");

  a_final_stroke_last: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT && out_load && strokes_left == '0) |=> (seg.valid && seg.last))
    else $error("final stroke of a glyph not marked last");

  a_start_origin: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_START) |=> (cursor_x == origin_x))
    else $error("start did not align cursor and line origin");

endmodule

// File: hdl/sfsg_seq.sv
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on sfsg_pkg.
module sfsg_seq
  import sfsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  seq_status_t status,
  output ucode_word_t cw
);

  // One control word per step, indexed by step code
  localparam ucode_word_t UCODE [STEP_COUNT] = '{
    '{in_ready: 1'b1, op: OP_LATCH,   jump: JC_ACCEPT,    target: ST_DECODE},   // wait
    '{in_ready: 1'b0, op: OP_NONE,    jump: JC_DISPATCH,  target: ST_WAIT},     // decode
    '{in_ready: 1'b0, op: OP_START,   jump: JC_ALWAYS,    target: ST_WAIT},     // start
    '{in_ready: 1'b0, op: OP_EMIT,    jump: JC_LAST_SENT, target: ST_ADV_CELL}, // emit
    '{in_ready: 1'b0, op: OP_CELL,    jump: JC_ALWAYS,    target: ST_WAIT},     // adv cell
    '{in_ready: 1'b0, op: OP_GAP,     jump: JC_ALWAYS,    target: ST_WAIT},     // adv gap
    '{in_ready: 1'b0, op: OP_NEWLINE, jump: JC_ALWAYS,    target: ST_WAIT},     // newline
    '{in_ready: 1'b0, op: OP_REPORT,  jump: JC_OUT_FREE,  target: ST_WAIT}      // finish
  };

  step_t step;
  step_t step_next;
  step_t dispatch;

  assign cw = UCODE[step];

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    unique case (status.kind)
      IK_START:   dispatch = ST_START;
      IK_GLYPH:   dispatch = ST_EMIT;
      IK_SPACE:   dispatch = ST_ADV_CELL;
      IK_NEWLINE: dispatch = ST_NEWLINE;
      IK_GAP:     dispatch = ST_ADV_GAP;
      IK_FINISH:  dispatch = ST_FINISH;
      default:    dispatch = ST_WAIT;
    endcase

    unique case (cw.jump)
      JC_ALWAYS:    step_next = cw.target;
      JC_ACCEPT:    step_next = status.accept ? cw.target : step;
      JC_DISPATCH:  step_next = dispatch;
      JC_LAST_SENT: step_next = (status.out_free && status.last_stroke) ? cw.target : step;
      JC_OUT_FREE:  step_next = status.out_free ? cw.target : step;
      default:      step_next = ST_WAIT;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    status.accept |=> step == ST_DECODE)
    else $error("item transfer did not lead to decode");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (step == ST_EMIT && !status.out_free) |=> step == ST_EMIT)
    else $error("emit step left while output register busy");

  a_glyph_emits: assert property (@(posedge clk) disable iff (rst)
    (step == ST_DECODE && status.kind == IK_GLYPH) |=> step == ST_EMIT)
    else $error("glyph item not dispatched to emit");

endmodule

// File: tb/sfsg_segment_check.sv
`timescale 1ns / 100ps
// Segment checker: predicts the segments of every accepted character item and compares.
// Depends on sfsg_pkg and the sfsg_item_if / sfsg_seg_if interfaces; watches the APB port.
module sfsg_segment_check
  import sfsg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  sfsg_item_if               item,
  sfsg_seg_if                seg,
  output int                 fail_count,
  output int                 outstanding
);

  // stroke bits within one box
  localparam logic [5:0] NONE = 6'h00;
  localparam logic [5:0] HT   = 6'h01;
  localparam logic [5:0] HB   = 6'h02;
  localparam logic [5:0] VL   = 6'h04;
  localparam logic [5:0] VR   = 6'h08;
  localparam logic [5:0] DL   = 6'h10;
  localparam logic [5:0] DR   = 6'h20;

  localparam logic [7:0] LINE_FEED = 8'h0A;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [15:0]        x;
    logic [15:0]        y;
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic               last;
  } seg_rec_t;

  seg_rec_t segs_due[$];
  seg_rec_t want;
  int       bad = 0;

  logic [7:0]  cell_size;
  logic [7:0]  top_r, top_g, top_b, bot_r, bot_g, bot_b;
  logic [15:0] cur_x, cur_y, org_x;

  // boxes packed as {top-left, top-right, bottom-right, bottom-left}
  function automatic logic [3:0][5:0] glyph_boxes(int slot);
    case (slot)
      0:  return {HT|HB|VL, HT|HB|VR, VR, VL};            // A
      1:  return {HT|VL|HB, HT|DL, HB|DR, HB|VL};
      2:  return {VL|HT, HT, HB, VL|HB};
      3:  return {HT|VL, HT|VR, DL, HB|VL};
      4:  return {HT|VL, HT|DL, HB, HB|VL};
      5:  return {HT|VL|HB, HT, NONE, VL};
      6:  return {DL, HT, HT|HB|VR, HB|VL};
      7:  return {VL|HB, VR|HB, VR, VL};
      8:  return {VR, NONE, NONE, VR};
      9:  return {NONE, VR, HB|VR, HB|VL};
      10: return {VL|HB, DL, DR, VL};
      11: return {VL, NONE, HB, HB|VL};
      12: return {VL|DR, DL|VR, VR, VL};
      13: return {VL|DR, VR, VR|DR, VL};
      14: return {VL|HT, HT|VR, VR|HB, VL|HB};
      15: return {VL|HT|HB, HT|HB|VR, NONE, VL};
      16: return {VL|HT, HT|VR, DR|VR|HB, VL|HB};
      17: return {VL|HT|HB, HT|HB|VR, DR, VL};
      18: return {VL|HT|HB, HT|HB, VR|HB, HB};
      19: return {HT|VR, HT, VL, NONE};
      20: return {VL, VR, VR|HB, HB|VL};
      21: return {VL, VR, DL, HB|VL};
      22: return {VL, VR, VR|DR, VL|DL};
      23: return {DR, DL, DR, DL};
      24: return {DR, DL, NONE, VR};
      25: return {HT, HT|DL, HB, HB|DL};                 // Z
      26: return {VL|HT, HT|VR, VR|HB, VL|HB};           // 0
      27: return {VR, NONE, NONE, VR};
      28: return {HT|HB, HT|HB|VR, HB, HB|VL};
      29: return {HT|HB, HT|HB|VR, HB|VR, HB};
      30: return {VL|HB, HB|VR, VR, NONE};
      31: return {VL|HT|HB, HT|HB, VR|HB, HB};
      32: return {HT|HB|VL, HT|HB, VR|HB, VL|HB};
      33: return {HT, HT|VR, VR, NONE};
      34: return {HT|HB|VL, HT|HB|VR, VR|HB, VL|HB};
      35: return {HT|HB|VL, HT|HB|VR, VR|HB, HB};        // 9
      36: return {HB, HB, NONE, NONE};                   // dash
      37: return {NONE, NONE, HB, HB};                   // underscore
      38: return {DL, DR|HB, VL, NONE};                  // question mark
      default: return '0;
    endcase
  endfunction

  // case-folded slot in the glyph table, -1 when the code has no glyph
  function automatic int glyph_slot(logic [7:0] ch);
    logic [7:0] c;
    c = ch;
    if (c >= "a" && c <= "z") c = c - ("a" - "A");
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "0" && c <= "9") return int'(c - "0") + 26;
    if (c == "-") return 36;
    if (c == "_") return 37;
    if (c == "?") return 38;
    return -1;
  endfunction

  function automatic void queue_seg(logic [KIND_W-1:0] kind, logic [15:0] x, logic [15:0] y,
                                    logic [LEN_W-1:0] len, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b, logic last);
    seg_rec_t s;
    s = '{kind: kind, x: x, y: y, len: len, r: r, g: g, b: b, last: last};
    segs_due.push_back(s);
  endfunction

  task automatic render_item(logic [CMD_W-1:0] cmd, logic [15:0] sx, logic [15:0] sy,
                             logic [7:0] ch);
    logic [15:0]     s, h, g, bx, by;
    logic [3:0][5:0] boxes;
    logic [5:0]      m;
    logic [7:0]      r, gr, b;
    logic [6:0]      len;
    logic            up, rt;
    int              slot, first, bi;
    s   = {8'b0, cell_size};
    h   = {9'b0, cell_size[7:1]};
    g   = {10'b0, cell_size[7:2]};
    len = h[6:0];
    case (cmd)
      CMD_START: begin
        cur_x = sx;
        org_x = sx;
        cur_y = sy;
      end
      CMD_FINISH: queue_seg(KIND_WIDTH, cur_x - org_x, '0, '0, '0, '0, '0, 1'b1);
      CMD_CHAR: begin
        slot = glyph_slot(ch);
        if (ch == " ") begin
          cur_x = cur_x + s + g;
        end else if (ch == LINE_FEED) begin
          cur_x = org_x;
          cur_y = cur_y + s + h;
        end else if (slot < 0) begin
          cur_x = cur_x + g;
        end else begin
          first = segs_due.size();
          boxes = glyph_boxes(slot);
          // bottom-left, bottom-right, top-right, top-left
          for (bi = 0; bi < 4; bi++) begin
            m  = boxes[bi];
            up = (bi >= 2);
            rt = (bi == 1 || bi == 2);
            bx = cur_x + (rt ? h : 16'd0);
            by = cur_y + (up ? 16'd0 : h);
            r  = up ? top_r : bot_r;
            gr = up ? top_g : bot_g;
            b  = up ? top_b : bot_b;
            if (m & HT) queue_seg(KIND_HORZ, bx, by, len, r, gr, b, 1'b0);
            if (m & HB) queue_seg(KIND_HORZ, bx, by + h, len, r, gr, b, 1'b0);
            if (m & VL) queue_seg(KIND_VERT, bx, by, len, r, gr, b, 1'b0);
            if (m & VR) queue_seg(KIND_VERT, bx + h, by, len, r, gr, b, 1'b0);
            if (m & DL) queue_seg(KIND_DIAG_DL, bx + h, by, len, r, gr, b, 1'b0);
            if (m & DR) queue_seg(KIND_DIAG_DR, bx, by, len, r, gr, b, 1'b0);
          end
          cur_x = cur_x + s + g;
          if (segs_due.size() > first) segs_due[segs_due.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      bad++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cell_size = 8'd16;
      {top_r, top_g, top_b} = {3{8'hFF}};
      {bot_r, bot_g, bot_b} = {3{8'hFF}};
      cur_x = '0;
      cur_y = '0;
      org_x = '0;
      segs_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_index_t'(paddr[4:2]))
            REG_GLYPH_SIZE:   cell_size = pwdata[7:0];
            REG_TOP_RED:      top_r = pwdata[7:0];
            REG_TOP_GREEN:    top_g = pwdata[7:0];
            REG_TOP_BLUE:     top_b = pwdata[7:0];
            REG_BOTTOM_RED:   bot_r = pwdata[7:0];
            REG_BOTTOM_GREEN: bot_g = pwdata[7:0];
            REG_BOTTOM_BLUE:  bot_b = pwdata[7:0];
            default: ;
          endcase
        end else begin
          case (reg_index_t'(paddr[4:2]))
            REG_GLYPH_SIZE:   check_field("prdata", {24'b0, cell_size}, prdata);
            REG_TOP_RED:      check_field("prdata", {24'b0, top_r}, prdata);
            REG_TOP_GREEN:    check_field("prdata", {24'b0, top_g}, prdata);
            REG_TOP_BLUE:     check_field("prdata", {24'b0, top_b}, prdata);
            REG_BOTTOM_RED:   check_field("prdata", {24'b0, bot_r}, prdata);
            REG_BOTTOM_GREEN: check_field("prdata", {24'b0, bot_g}, prdata);
            REG_BOTTOM_BLUE:  check_field("prdata", {24'b0, bot_b}, prdata);
            default: ;
          endcase
        end
      end
      if (item.valid && item.ready)
        render_item(item.cmd, item.start_x, item.start_y, item.char_code);
      if (seg.valid && seg.ready) begin
        if (segs_due.size() == 0) begin
          $error("segment transfer with nothing expected: kind %0d x %0h y %0h",
                 seg.seg_kind, seg.seg_x, seg.seg_y);
          bad++;
        end else begin
          want = segs_due.pop_front();
          check_field("seg_kind", {29'b0, want.kind}, {29'b0, seg.seg_kind});
          check_field("seg_x", {16'b0, want.x}, {16'b0, seg.seg_x});
          check_field("seg_y", {16'b0, want.y}, {16'b0, seg.seg_y});
          check_field("seg_len", {25'b0, want.len}, {25'b0, seg.seg_len});
          check_field("red", {24'b0, want.r}, {24'b0, seg.red});
          check_field("green", {24'b0, want.g}, {24'b0, seg.green});
          check_field("blue", {24'b0, want.b}, {24'b0, seg.blue});
          check_field("last", {31'b0, want.last}, {31'b0, seg.last});
        end
      end
    end
    outstanding <= segs_due.size();
    fail_count  <= bad;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the stroke-font segment generator testbench: clock, reset, stimulus and verdict.
// Depends on sfsg_pkg, the channel interfaces, the RTL top and sfsg_segment_check.
module tb;
  import sfsg_pkg::*;

  localparam int CLK_HALF   = 2;
  localparam int SETTLE     = 16;         // covers a no-result item still in flight
  localparam int TIMEOUT_NS = 2_400_000;  // far above the slowest legal run
  localparam int PHASE_ITEMS = 75;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 outstanding;
  int                 burst_left = 0;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_THIRDS, RX_LONG} rx_mode_t;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_span = 0;
  int       rx_tick = 0;

  sfsg_item_if item_ch();
  sfsg_seg_if  seg_ch();

  stroke_font_segment_generator dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .seg     (seg_ch)
  );

  // Predicts and compares every segment; also checks register reads.
  sfsg_segment_check checker_i (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .item        (item_ch),
    .seg         (seg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #(CLK_HALF) clk = ~clk;

  // Hard stop in case the block hangs or a segment never shows up.
  initial begin
    #(TIMEOUT_NS);
    $display("stroke_font_segment_generator regression: fail");
    $finish;
  end

  // Segment receiver: switches between stall patterns after each random span.
  // Long-stall mode holds ready low in runs longer than its high runs, so a glyph's
  // strokes pile up behind the output register.
  initial begin
    seg_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(16, 96);
      end
      rx_span--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   seg_ch.ready <= 1'b1;
        RX_RANDOM: seg_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_THIRDS: seg_ch.ready <= (rx_tick % 3 != 0);
        default:   seg_ch.ready <= (rx_span % 32 < 12);
      endcase
    end
  end

  // One item transfer. The sender runs in bursts; between bursts valid drops
  // for a random gap, so idle cycles land on every step of the block's work.
  // valid stays high across back-to-back transfers within a burst.
  task automatic send_item(cmd_t c, logic [15:0] x, logic [15:0] y, logic [7:0] ch);
    if (burst_left == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    item_ch.valid     <= 1'b1;
    item_ch.cmd       <= c;
    item_ch.start_x   <= x;
    item_ch.start_y   <= y;
    item_ch.char_code <= ch;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted segment has been taken.
  // The first edge lets the checker's count catch up with the last transfer;
  // the settle time covers a trailing space/newline/start still in flight.
  task automatic drain_segments();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB transfers: setup, access, then idle with psel low so psel never toggles
  // twice in a single step.
  task automatic apb_xfer(logic wr, reg_index_t idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};   // upper bits are don't-care for 8-bit registers
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // New cell size and colors, written only with the block idle, then read back.
  task automatic set_look(logic [7:0] size, logic [7:0] tr, logic [7:0] tg, logic [7:0] tb,
                          logic [7:0] br, logic [7:0] bg, logic [7:0] bb);
    drain_segments();
    apb_xfer(1'b1, REG_GLYPH_SIZE, size);
    apb_xfer(1'b1, REG_TOP_RED, tr);
    apb_xfer(1'b1, REG_TOP_GREEN, tg);
    apb_xfer(1'b1, REG_TOP_BLUE, tb);
    apb_xfer(1'b1, REG_BOTTOM_RED, br);
    apb_xfer(1'b1, REG_BOTTOM_GREEN, bg);
    apb_xfer(1'b1, REG_BOTTOM_BLUE, bb);
    for (int i = 0; i <= REG_BOTTOM_BLUE; i++)
      apb_xfer(1'b0, reg_index_t'(i), 8'h00);
  endtask

  // Coordinates hug the 16-bit edges a quarter of the time each, to force wrap.
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return 16'h7FFF - 16'($urandom_range(0, 300));
      1:       return 16'h8000 + 16'($urandom_range(0, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly glyphs (both cases), some layout codes, and a tail of arbitrary bytes.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CH_UPPER_A + 8'($urandom_range(0, 25));
    if (r < 60) return CH_LOWER_A + 8'($urandom_range(0, 25));
    if (r < 72) return CH_DIGIT_0 + 8'($urandom_range(0, 9));
    if (r < 74) return CH_DASH;
    if (r < 76) return CH_UNDERSCORE;
    if (r < 78) return CH_QUESTION;
    if (r < 85) return CH_SPACE;
    if (r < 89) return CH_NEWLINE;
    return 8'($urandom);
  endfunction

  // Random traffic: mostly well-formed strings (start, 1..12 characters,
  // usually a finish), with stray commands mixed in. Command three is only
  // noise and does not count toward the item budget.
  task automatic run_phase(int budget);
    int   sent;
    int   n;
    cmd_t c;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        send_item(CMD_START, rand_coord(), rand_coord(), 8'($urandom));
        n = $urandom_range(1, 12);
        repeat (n) send_item(CMD_CHAR, 16'($urandom), 16'($urandom), pick_char());
        sent += n + 1;
        if ($urandom_range(0, 9) != 0) begin
          send_item(CMD_FINISH, 16'($urandom), 16'($urandom), 8'($urandom));
          sent++;
        end
      end else begin
        c = cmd_t'($urandom_range(0, 3));
        send_item(c, 16'($urandom), 16'($urandom), 8'($urandom));
        if (c != CMD_NONE) sent++;
      end
    end
  endtask

  initial begin
    // every block input known from time zero
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    item_ch.valid     = 1'b0;
    item_ch.cmd       = CMD_START;
    item_ch.start_x   = '0;
    item_ch.start_y   = '0;
    item_ch.char_code = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset look (size 16, white). Finish before any start reports
    // zero width; a glyph at the reset cursor; then a start right at the
    // positive x edge so the first strokes wrap.
    send_item(CMD_FINISH, '0, '0, '0);
    send_item(CMD_CHAR, '0, '0, CH_UPPER_A);
    send_item(CMD_START, 16'h7FFF, 16'h8000, '0);
    send_item(CMD_CHAR, '0, '0, CH_UPPER_Z);
    send_item(CMD_CHAR, '0, '0, CH_LOWER_Z);      // folds to upper case
    send_item(CMD_CHAR, '0, '0, CH_DIGIT_0);
    send_item(CMD_CHAR, '0, '0, CH_DIGIT_9);
    send_item(CMD_CHAR, '0, '0, CH_DASH);
    send_item(CMD_CHAR, '0, '0, CH_UNDERSCORE);
    send_item(CMD_CHAR, '0, '0, CH_QUESTION);
    send_item(CMD_CHAR, '0, '0, CH_SPACE);
    send_item(CMD_CHAR, '0, '0, CH_NEWLINE);
    send_item(CMD_CHAR, '0, '0, 8'h00);           // unknown: code zero, small gap
    send_item(CMD_CHAR, '0, '0, 8'hFF);           // unknown: top of the code range
    send_item(CMD_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);  // ignored command
    send_item(CMD_FINISH, '0, '0, '0);
    send_item(CMD_START, 16'h8000, 16'h7FFF, '0);
    send_item(CMD_CHAR, '0, '0, "M");             // diagonals in both directions
    send_item(CMD_FINISH, '0, '0, '0);

    // Degenerate cells: size one gives zero-length strokes and no gap,
    // size zero also zero advance. Top and bottom colors differ in both of these looks.
    set_look(8'd1, 8'h12, 8'h34, 8'h56, 8'hA5, 8'h5A, 8'hC3);
    send_item(CMD_START, '0, '0, '0);
    send_item(CMD_CHAR, '0, '0, "X");
    send_item(CMD_CHAR, '0, '0, CH_SPACE);
    send_item(CMD_FINISH, '0, '0, '0);
    set_look(8'd0, 8'hC3, 8'h5A, 8'hA5, 8'h56, 8'h34, 8'h12);
    send_item(CMD_CHAR, '0, '0, "K");
    send_item(CMD_CHAR, '0, '0, CH_NEWLINE);
    send_item(CMD_FINISH, '0, '0, '0);

    // Random phases, each behind a full drain and a register update:
    // largest cell with black/white split, smallest legal cells, then random.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_look(8'd255, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        1:       set_look(8'd2, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        2:       set_look(8'd3, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
        default: set_look(8'($urandom_range(2, 255)), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      run_phase(PHASE_ITEMS);
    end

    drain_segments();
    if (fail_count == 0 && outstanding == 0) begin
      $display("stroke_font_segment_generator regression: pass");
    end else begin
      $display("stroke_font_segment_generator regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sfsg_pkg.sv
hdl/sfsg_ifs.sv
hdl/sfsg_seq.sv
hdl/stroke_font_segment_generator.sv
tb/sfsg_segment_check.sv
tb/tb.sv
